/* sv/mdtp_pkg.sv */
// Package for the method descriptor type parser.
// Parse mode codes, character constants, type codes and the primitive lookup.
// No dependencies.
package mdtp_pkg;

	// Parse mode codes
	localparam logic [2:0] MODE_PARAM  = 3'd0;
	localparam logic [2:0] MODE_ARRAY  = 3'd1;
	localparam logic [2:0] MODE_CLASS  = 3'd2;
	localparam logic [2:0] MODE_RETURN = 3'd3;
	localparam logic [2:0] MODE_DONE   = 3'd4;

	// Descriptor characters
	localparam logic [7:0] CH_RPAREN = 8'h29; // ')'
	localparam logic [7:0] CH_SEMI   = 8'h3B; // ';'
	localparam logic [7:0] CH_LBRACK = 8'h5B; // '['
	localparam logic [7:0] CH_L      = 8'h4C; // 'L'
	localparam logic [7:0] CH_V      = 8'h56; // 'V'
	localparam logic [7:0] CH_B      = 8'h42;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_F      = 8'h46;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_J      = 8'h4A;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_Z      = 8'h5A;

	// Type codes
	localparam logic [3:0] TC_BYTE    = 4'd0;
	localparam logic [3:0] TC_CHAR    = 4'd1;
	localparam logic [3:0] TC_DOUBLE  = 4'd2;
	localparam logic [3:0] TC_FLOAT   = 4'd3;
	localparam logic [3:0] TC_INT     = 4'd4;
	localparam logic [3:0] TC_LONG    = 4'd5;
	localparam logic [3:0] TC_SHORT   = 4'd6;
	localparam logic [3:0] TC_BOOLEAN = 4'd7;
	localparam logic [3:0] TC_ARRAY   = 4'd8;
	localparam logic [3:0] TC_OBJECT  = 4'd9;
	localparam logic [3:0] TC_VOID    = 4'd10;
	localparam logic [3:0] TC_NONE    = 4'd15;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	// Primitive letter to type code, TC_NONE when not a primitive
	function automatic logic [3:0] primitive_code(input logic [7:0] c);
		logic [3:0] code;
		case (c)
			CH_B:    code = TC_BYTE;
			CH_C:    code = TC_CHAR;
			CH_D:    code = TC_DOUBLE;
			CH_F:    code = TC_FLOAT;
			CH_I:    code = TC_INT;
			CH_J:    code = TC_LONG;
			CH_S:    code = TC_SHORT;
			CH_Z:    code = TC_BOOLEAN;
			default: code = TC_NONE;
		endcase
		return code;
	endfunction

endpackage

/* sv/method_descriptor_type_parser_top.sv */
// Method descriptor type parser, top level.
// Input register, one step of mode logic, result register. Uses mdtp_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  in      | in_valid / in_ready  | char_code[7:0], start_flag
//  out     | out_valid / out_ready| type_code[3:0], param_index[7:0],
//          |                      | is_return
//
// One character per cycle while no result waits on out_ready. A character
// is held in the input register and any result goes to the result register.
// The mode and count registers step once per character in the input stage.
// arst_n clears the mode to the parameter region, the count to zero and both
// valid flags. A stalled result holds only the characters that would emit a
// result; characters with no result keep flowing.
module method_descriptor_type_parser_top
	import mdtp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       start_flag,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] type_code,
	output logic [7:0] param_index,
	output logic       is_return
);

	// Input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       start_s1;

	// Parser state
	logic [2:0] mode_q;
	logic [7:0] count_q;

	// Result register
	logic       out_valid_q;
	logic [3:0] type_q;
	logic [7:0] index_q;
	logic       ret_q;

	// Step logic
	logic [2:0] mode_eff;
	logic [7:0] count_eff;
	logic [2:0] mode_nx;
	logic [7:0] count_nx;
	logic       emit;
	logic       emit_ret;
	logic [3:0] emit_code;
	logic [3:0] prim;
	logic       adv_s1;
	logic       out_free;

	// Start flag restarts the parse on this same character
	always_comb begin
		mode_eff  = start_s1 ? MODE_PARAM : mode_q;
		count_eff = start_s1 ? 8'd0 : count_q;
		prim      = primitive_code(char_s1);
		mode_nx   = mode_eff;
		count_nx  = count_eff;
		emit      = 1'b0;
		emit_ret  = 1'b0;
		emit_code = TC_NONE;
		case (mode_eff)
			MODE_PARAM: begin
				if (char_s1 == CH_RPAREN) begin
					mode_nx = MODE_RETURN;
				end else if (char_s1 == CH_LBRACK) begin
					mode_nx   = MODE_ARRAY;
					emit      = 1'b1;
					emit_code = TC_ARRAY;
				end else if (char_s1 == CH_L) begin
					mode_nx   = MODE_CLASS;
					emit      = 1'b1;
					emit_code = TC_OBJECT;
				end else if (prim != TC_NONE) begin
					emit      = 1'b1;
					emit_code = prim;
				end
				if (emit && count_eff != COUNT_MAX) begin
					count_nx = count_eff + 8'd1;
				end
			end
			MODE_ARRAY: begin
				// component after the brackets is consumed; a class name is skipped
				if (char_s1 != CH_LBRACK) begin
					mode_nx = (char_s1 == CH_L) ? MODE_CLASS : MODE_PARAM;
				end
			end
			MODE_CLASS: begin
				if (char_s1 == CH_SEMI) begin
					mode_nx = MODE_PARAM;
				end
			end
			MODE_RETURN: begin
				if (char_s1 == CH_V) begin
					emit_code = TC_VOID;
				end else if (char_s1 == CH_LBRACK || char_s1 == CH_L) begin
					emit_code = TC_OBJECT;
				end else begin
					emit_code = prim;
				end
				if (emit_code != TC_NONE) begin
					emit     = 1'b1;
					emit_ret = 1'b1;
					mode_nx  = MODE_DONE;
				end
			end
			default: begin
				// done: ignore everything until a start
			end
		endcase
	end

	// Handshake
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1  <= char_code;
			start_s1 <= start_flag;
		end
	end

	// Parser state advances once per character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PARAM;
			count_q <= 8'd0;
		end else if (adv_s1) begin
			mode_q  <= mode_nx;
			count_q <= count_nx;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			type_q  <= emit_code;
			index_q <= emit_ret ? 8'd0 : count_eff;
			ret_q   <= emit_ret;
		end
	end

	assign out_valid   = out_valid_q;
	assign type_code   = type_q;
	assign param_index = index_q;
	assign is_return   = ret_q;

	// Checks
	a_ret_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ret_q |-> index_q == 8'd0)
		else $error("return result with nonzero index");

	a_ret_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && emit_ret |=> mode_q == MODE_DONE)
		else $error("parser not done after return type");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> type_q <= TC_VOID)
		else $error("type code out of range");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !start_s1 && mode_q == MODE_DONE |-> !emit)
		else $error("result emitted after descriptor end");

endmodule
